[hw/rtl/mtkh_pkg.sv]
package mtkh_pkg;

	// Number of layers that have their own key entry.
	localparam int NUM_LAYERS = 4;
	localparam int LAYER_IDX_W = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;

	// Widths fixed by the interface.
	localparam int CFG_IDX_W = 2;
	localparam int ENTRY_W = 37;
	localparam int TIME_W = 32;
	localparam int DELAY_W = 16;

	// Mod kind of a key entry.
	typedef enum logic [1:0] {
		KIND_NONE     = 2'd0,
		KIND_LAYER_MO = 2'd1,
		KIND_LAYER_TG = 2'd2,
		KIND_MODIFIER = 2'd3
	} kind_t;

	// Action code of a result.
	typedef enum logic [2:0] {
		ACT_KEY          = 3'd0,
		ACT_LAYER_MO     = 3'd1,
		ACT_LAYER_TG     = 3'd2,
		ACT_LAYER_REVERT = 3'd3,
		ACT_MOD_SET      = 3'd4,
		ACT_MOD_RESET    = 3'd5
	} action_t;

	// One layer's key entry, packed as in the configuration register.
	typedef struct packed {
		logic [DELAY_W-1:0] delay;
		logic [2:0]         target;
		kind_t              kind;
		logic [7:0]         modifier;
		logic [7:0]         key;
	} entry_t;

	// One result.
	typedef struct packed {
		action_t    action;
		logic [7:0] key_code;
		logic       key_down;
		logic [7:0] modifier_code;
		logic [2:0] target_layer;
		logic       last_of_run;
	} result_t;

endpackage

[hw/rtl/mod_tap_key_handler_unit.sv]
// Stages: an accepted request is registered in the input stage, its results in the result
// buffer, which presents the first; a second result follows once the first is taken.
// Throughput: one request per cycle while result_stall is low and each request gives
// at most one result; one that gives two holds back the next until both are taken.
// Reset (arst_n low, asynchronous): key released, no mod held, press time and all layer
// entries cleared, input and result stages empty.
module mod_tap_key_handler_unit
	import mtkh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Configuration write channel.
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ENTRY_W-1:0]   cfg_data,
	// Poll request channel.
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 pin_pressed,
	input  logic [1:0]           active_layer,
	input  logic [TIME_W-1:0]    time_now,
	// Result channel.
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [2:0]           action,
	output logic [7:0]           key_code,
	output logic                 key_down,
	output logic [7:0]           modifier_code,
	output logic [2:0]           target_layer,
	output logic                 last_of_run
);

	// Layer entries.
	entry_t layer_entry_q [NUM_LAYERS];

	// Key state.
	logic              was_pressed_q;
	logic              holding_mod_q;
	logic [TIME_W-1:0] press_time_q;

	// Input stage.
	logic              valid_s1;
	logic              pressed_s1;
	logic [1:0]        layer_s1;
	logic [TIME_W-1:0] time_s1;

	// Result buffer: slot 0 is presented, slot 1 waits behind it.
	result_t    slot0_q;
	result_t    slot1_q;
	logic [1:0] count_q;

	// Combinational decode of the request in the input stage.
	logic                   pop;
	logic                   proc;
	logic [LAYER_IDX_W-1:0] layer_sel;
	entry_t                 entry;
	logic                   rise;
	logic                   fall;
	logic                   held;
	logic [TIME_W-1:0]      elapsed;
	logic                   expired;
	logic                   fire;
	logic [1:0]             n_res;
	result_t                res0;
	result_t                res1;

	function automatic result_t make_res(action_t act, logic [7:0] key, logic down,
			logic [7:0] modifier, logic [2:0] layer);
		result_t r;
		r.action        = act;
		r.key_code      = key;
		r.key_down      = down;
		r.modifier_code = modifier;
		r.target_layer  = layer;
		r.last_of_run   = 1'b0;
		return r;
	endfunction

	// Configuration writes are taken at any time.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LAYERS; i++) begin
				layer_entry_q[i] <= '0;
			end
		end else if (cfg_valid && (int'(cfg_index) < NUM_LAYERS)) begin
			layer_entry_q[LAYER_IDX_W'(cfg_index)] <= entry_t'(cfg_data);
		end
	end

	// Buffer handshake: a request is processed when the buffer is empty or is emptying.
	assign pop        = (count_q != 2'd0) && !result_stall;
	assign proc       = valid_s1 && ((count_q == 2'd0) || ((count_q == 2'd1) && pop));
	assign item_stall = valid_s1 && !proc;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			pressed_s1 <= pin_pressed;
			layer_s1   <= active_layer;
			time_s1    <= time_now;
		end
	end

	// Entry lookup with out-of-range layers clamped to the last one.
	assign layer_sel = (int'(layer_s1) >= NUM_LAYERS) ? LAYER_IDX_W'(NUM_LAYERS - 1)
	                                                  : LAYER_IDX_W'(layer_s1);
	assign entry = layer_entry_q[layer_sel];

	// Edge detection and hold timeout.
	assign rise    = pressed_s1 && !was_pressed_q;
	assign fall    = !pressed_s1 && was_pressed_q;
	assign held    = pressed_s1 && was_pressed_q;
	assign elapsed = time_s1 - press_time_q;
	assign expired = elapsed > TIME_W'(entry.delay);
	assign fire    = (entry.kind != KIND_NONE) &&
	                 ((rise && (entry.delay == '0)) || (held && !holding_mod_q && expired));

	// Result generation.
	always_comb begin
		n_res = 2'd0;
		res0  = '0;
		res1  = '0;
		if (fire) begin
			unique case (entry.kind)
				KIND_LAYER_MO: begin
					res0  = make_res(ACT_LAYER_MO, 8'd0, 1'b0, 8'd0, entry.target);
					n_res = 2'd1;
				end
				KIND_LAYER_TG: begin
					res0  = make_res(ACT_LAYER_TG, 8'd0, 1'b0, 8'd0, entry.target);
					n_res = 2'd1;
				end
				default: begin
					res0  = make_res(ACT_MOD_SET, 8'd0, 1'b0, entry.modifier, 3'd0);
					res1  = make_res(ACT_KEY, 8'd0, 1'b1, 8'd0, 3'd0);
					n_res = 2'd2;
				end
			endcase
		end else if (rise) begin
			if (entry.kind == KIND_NONE) begin
				res0  = make_res(ACT_KEY, entry.key, 1'b1, 8'd0, 3'd0);
				n_res = 2'd1;
			end
		end else if (fall) begin
			if (holding_mod_q) begin
				if (entry.kind == KIND_LAYER_MO) begin
					res0  = make_res(ACT_LAYER_REVERT, 8'd0, 1'b0, 8'd0, 3'd0);
					n_res = 2'd1;
				end else begin
					res0  = make_res(ACT_MOD_RESET, 8'd0, 1'b0, entry.modifier, 3'd0);
					res1  = make_res(ACT_KEY, 8'd0, 1'b0, 8'd0, 3'd0);
					n_res = 2'd2;
				end
			end else if (entry.kind != KIND_NONE) begin
				// A release before the hold fires is a tap.
				res0  = make_res(ACT_KEY, entry.key, 1'b1, 8'd0, 3'd0);
				res1  = make_res(ACT_KEY, entry.key, 1'b0, 8'd0, 3'd0);
				n_res = 2'd2;
			end else begin
				res0  = make_res(ACT_KEY, entry.key, 1'b0, 8'd0, 3'd0);
				n_res = 2'd1;
			end
		end
		res0.last_of_run = (n_res == 2'd1);
		res1.last_of_run = 1'b1;
	end

	// Key state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			was_pressed_q <= 1'b0;
			holding_mod_q <= 1'b0;
			press_time_q  <= '0;
		end else if (proc) begin
			was_pressed_q <= pressed_s1;
			if (fire) begin
				holding_mod_q <= 1'b1;
			end else if (rise) begin
				holding_mod_q <= 1'b0;
			end
			if (rise && !fire && (entry.kind != KIND_NONE)) begin
				press_time_q <= time_s1;
			end
		end
	end

	// Result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (proc) begin
			count_q <= n_res;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	// Result ports.
	assign result_valid  = (count_q != 2'd0);
	assign action        = slot0_q.action;
	assign key_code      = slot0_q.key_code;
	assign key_down      = slot0_q.key_down;
	assign modifier_code = slot0_q.modifier_code;
	assign target_layer  = slot0_q.target_layer;
	assign last_of_run   = slot0_q.last_of_run;

`ifndef SYNTHESIS
	// The buffer never holds more than two results.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result buffer count out of range");

	// A presented result with another behind it is not the last of its run.
	a_first_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd2) |-> !last_of_run)
		else $error("first of two results marked last");

	// A lone presented result closes its run.
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == 2'd1) |-> last_of_run)
		else $error("single result not marked last");

	// A stalled request stays in the input stage.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |=> valid_s1)
		else $error("stalled request lost");
`endif

endmodule
